FILE: hdl/rpg_pkg.sv
// Ring pattern generator package: widths, register indexes, reset values,
// state encoding and the command/status structs shared by controller and datapath.
// No dependencies.
package rpg_pkg;

   // largest supported image side, as log2
   localparam int MaxDimLog2 = 10;
   localparam int DimW       = MaxDimLog2;
   localparam int LogW       = 4;

   // field widths
   localparam int RadiusW    = 12;
   localparam int CurRadiusW = 13;
   localparam int RingWidthW = 13;
   localparam int CountW     = 2 * DimW + 1;
   localparam int IndexW     = 2 * DimW;
   localparam int WeightW    = 32;

   // ring test arithmetic
   localparam int SqW    = 2 * DimW - 1;
   localparam int SumW   = SqW + 1;
   localparam int D4W    = SumW + 2;
   localparam int TwoRW  = CurRadiusW + 1;
   localparam int OuterW = 2 * (TwoRW + 1);
   localparam int InnerW = 2 * TwoRW;
   localparam int CmpW   = (D4W > OuterW) ? D4W : OuterW;

   // reciprocal divider
   localparam int RemW    = CountW + 1;
   localparam int DivCntW = $clog2(WeightW);

   // stream payloads
   localparam int ReqDataW  = 8;
   localparam int RspFieldW = IndexW + WeightW + RadiusW + CountW;
   localparam int RspDataW  = ((RspFieldW + 7) / 8) * 8;

   // register port
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = RingWidthW;

   localparam logic [CsrIndexW-1:0] CsrStartRadius = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrRadiusStep  = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrEndRadius   = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrRingWidth   = 3'd3;
   localparam logic [CsrIndexW-1:0] CsrWidthLog2   = 3'd4;
   localparam logic [CsrIndexW-1:0] CsrHeightLog2  = 3'd5;

   localparam logic [RadiusW-1:0]    StartRadiusRst = 12'd5;
   localparam logic [RadiusW-1:0]    RadiusStepRst  = 12'd2;
   localparam logic [RadiusW-1:0]    EndRadiusRst   = 12'd5;
   localparam logic [RingWidthW-1:0] RingWidthRst   = 13'd13;
   localparam logic [LogW-1:0]       WidthLog2Rst   = 4'd10;
   localparam logic [LogW-1:0]       HeightLog2Rst  = 4'd10;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SQUARE = 4'b0010,
      ST_EVAL   = 4'b0100,
      ST_DIV    = 4'b1000
   } rpg_state_type;

   typedef struct packed {
      logic capture;   // latch the request payload
      logic eval;      // apply the pixel step
      logic div_step;  // one reciprocal iteration
   } rpg_cmd_type;

   typedef struct packed {
      logic emit;         // current request yields a result
      logic pass_switch;  // current request ends the counting pass
      logic out_busy;     // output register holds an untaken result
      logic div_last;     // final reciprocal iteration
   } rpg_status_type;

endpackage

FILE: hdl/rpg_ctrl.sv
// Ring pattern generator controller: request handshake and sequencing of
// square, evaluate and reciprocal phases.
// Depends on rpg_pkg.
module rpg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output rpg_pkg::rpg_cmd_type    cmd,
   input  rpg_pkg::rpg_status_type status
);

   rpg_pkg::rpg_state_type state_ff, state_in;

   assign req_tready = (state_ff == rpg_pkg::ST_IDLE);

   always_comb begin
      cmd.capture  = req_tvalid && req_tready;
      cmd.eval     = (state_ff == rpg_pkg::ST_EVAL) && !(status.emit && status.out_busy);
      cmd.div_step = (state_ff == rpg_pkg::ST_DIV);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpg_pkg::ST_IDLE: begin
            if (cmd.capture) state_in = rpg_pkg::ST_SQUARE;
         end
         rpg_pkg::ST_SQUARE: begin
            state_in = rpg_pkg::ST_EVAL;
         end
         rpg_pkg::ST_EVAL: begin
            // an emitting request holds while the previous result still sits in the output register
            if (cmd.eval) state_in = status.pass_switch ? rpg_pkg::ST_DIV : rpg_pkg::ST_IDLE;
         end
         rpg_pkg::ST_DIV: begin
            if (status.div_last) state_in = rpg_pkg::ST_IDLE;
         end
         default: begin
            state_in = rpg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rpg_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   a_accept_to_square: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == rpg_pkg::ST_SQUARE)
      else $error("accepted request did not enter square phase");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rpg_pkg::ST_EVAL && status.emit && status.out_busy) |-> !cmd.eval)
      else $error("evaluate issued while output register full");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rpg_pkg::ST_DIV && !status.div_last) |=> state_ff == rpg_pkg::ST_DIV)
      else $error("reciprocal left before last iteration");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.eval, cmd.div_step}))
      else $error("overlapping datapath commands");

endmodule

FILE: hdl/rpg_datapath.sv
// Ring pattern generator datapath: registers, scan position, ring test,
// pixel count, iterative reciprocal and the output register.
// Depends on rpg_pkg; driven by rpg_ctrl commands.
module rpg_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [rpg_pkg::ReqDataW-1:0]     req_tdata,
   input  logic                             csr_wr_en,
   input  logic [rpg_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [rpg_pkg::CsrDataW-1:0]     csr_wdata,
   input  rpg_pkg::rpg_cmd_type             cmd,
   output rpg_pkg::rpg_status_type          status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rpg_pkg::RspDataW-1:0]     rsp_tdata,
   output logic                             rsp_tlast
);

   // configuration
   logic [rpg_pkg::RadiusW-1:0]    start_ff, step_ff, end_ff;
   logic [rpg_pkg::RingWidthW-1:0] rwidth_ff;
   logic [rpg_pkg::LogW-1:0]       wl_ff, hl_ff;

   // image state
   logic [rpg_pkg::CurRadiusW-1:0] radius_ff, radius_in;
   logic [rpg_pkg::DimW-1:0]       col_ff, col_in, row_ff, row_in;
   logic                           pass_ff, pass_in;
   logic [rpg_pkg::CountW-1:0]     count_ff, count_in;
   logic [rpg_pkg::WeightW-1:0]    weight_ff, weight_in;

   // request payload and squares
   logic                           restart_ff;
   logic [rpg_pkg::SqW-1:0]        xsq_ff, ysq_ff;
   logic [rpg_pkg::OuterW-1:0]     outer_ff;
   logic [rpg_pkg::InnerW-1:0]     inner_ff;
   logic                           inner_en_ff;

   // reciprocal
   logic [rpg_pkg::RemW-1:0]       rem_ff, rem_in;
   logic [rpg_pkg::WeightW-1:0]    quo_ff, quo_in;
   logic [rpg_pkg::DivCntW-1:0]    dcnt_ff, dcnt_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rpg_pkg::RspDataW-1:0]   rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;

   // geometry
   logic [rpg_pkg::LogW-1:0]   wl_sat, hl_sat;
   logic [rpg_pkg::DimW:0]     w_full, h_full;
   logic [rpg_pkg::DimW-1:0]   wmask, hmask, half_w, half_h, col_m, row_m, xi, yi;
   logic signed [rpg_pkg::DimW:0]     x, y;
   logic signed [2*rpg_pkg::DimW+1:0] xsq_full, ysq_full;
   logic [rpg_pkg::TwoRW-1:0]  two_r, inner_base;
   logic [rpg_pkg::TwoRW:0]    outer_base;
   logic [rpg_pkg::SumW-1:0]   dsum;
   logic [rpg_pkg::CmpW-1:0]   d4c, outer_c, inner_c;
   logic                       on, at_start, series_end, zero_dim, row_end, pass_end, active;
   logic [rpg_pkg::IndexW-1:0] pix_index;

   // divider step
   logic [rpg_pkg::RemW-1:0]    trial, count_ext;
   logic                        q_bit;
   logic [rpg_pkg::WeightW-1:0] quo_next;

   always_comb begin
      wl_sat = (wl_ff > rpg_pkg::LogW'(rpg_pkg::MaxDimLog2)) ?
               rpg_pkg::LogW'(rpg_pkg::MaxDimLog2) : wl_ff;
      hl_sat = (hl_ff > rpg_pkg::LogW'(rpg_pkg::MaxDimLog2)) ?
               rpg_pkg::LogW'(rpg_pkg::MaxDimLog2) : hl_ff;
      w_full = (rpg_pkg::DimW+1)'(1) << wl_sat;
      h_full = (rpg_pkg::DimW+1)'(1) << hl_sat;
      wmask  = rpg_pkg::DimW'(w_full - (rpg_pkg::DimW+1)'(1));
      hmask  = rpg_pkg::DimW'(h_full - (rpg_pkg::DimW+1)'(1));
      half_w = rpg_pkg::DimW'(w_full >> 1);
      half_h = rpg_pkg::DimW'(h_full >> 1);
      col_m  = col_ff & wmask;
      row_m  = row_ff & hmask;
      x = $signed({1'b0, col_m}) - $signed({1'b0, half_w});
      y = $signed({1'b0, row_m}) - $signed({1'b0, half_h});
      xsq_full = x * x;
      ysq_full = y * y;
      two_r      = {radius_ff, 1'b0};
      outer_base = (rpg_pkg::TwoRW+1)'(two_r) + (rpg_pkg::TwoRW+1)'(rwidth_ff);
      inner_base = two_r - rpg_pkg::TwoRW'(rwidth_ff);
   end

   // squares are registered every cycle; the scan state is steady from
   // request capture until evaluation
   always_ff @(posedge clock) begin
      xsq_ff      <= xsq_full[rpg_pkg::SqW-1:0];
      ysq_ff      <= ysq_full[rpg_pkg::SqW-1:0];
      outer_ff    <= outer_base * outer_base;
      inner_ff    <= inner_base * inner_base;
      inner_en_ff <= (two_r >= rpg_pkg::TwoRW'(rwidth_ff));
      if (cmd.capture) restart_ff <= req_tdata[0];
   end

   always_comb begin
      dsum    = rpg_pkg::SumW'(xsq_ff) + rpg_pkg::SumW'(ysq_ff);
      d4c     = rpg_pkg::CmpW'({dsum, 2'b00});
      outer_c = rpg_pkg::CmpW'(outer_ff);
      inner_c = rpg_pkg::CmpW'(inner_ff);
      on      = (d4c < outer_c) && (!inner_en_ff || (d4c > inner_c));

      at_start   = !pass_ff && (col_ff == '0) && (row_ff == '0);
      series_end = at_start && (radius_ff > rpg_pkg::CurRadiusW'(end_ff));
      zero_dim   = (wl_sat == '0) || (hl_sat == '0);
      row_end    = (col_m == wmask);
      pass_end   = row_end && (row_m == hmask);
      active     = !restart_ff && !series_end && !zero_dim;

      // quadrant swap: shift the center to the origin
      xi = (col_m + half_w) & wmask;
      yi = (row_m + half_h) & hmask;
      pix_index = rpg_pkg::IndexW'(xi) + (rpg_pkg::IndexW'(yi) << wl_sat);

      status.emit        = active && pass_ff;
      status.pass_switch = active && !pass_ff && pass_end;
      status.out_busy    = rsp_valid_ff && !rsp_tready;
      status.div_last    = (dcnt_ff == rpg_pkg::DivCntW'(rpg_pkg::WeightW - 1));
   end

   // restoring division of 2^(WeightW-1) by the count, one quotient bit per step
   always_comb begin
      count_ext = rpg_pkg::RemW'(count_ff);
      trial     = {rem_ff[rpg_pkg::RemW-2:0], (dcnt_ff == '0)};
      q_bit     = (trial >= count_ext);
      quo_next  = {quo_ff[rpg_pkg::WeightW-2:0], q_bit};
   end

   always_comb begin
      radius_in = radius_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pass_in   = pass_ff;
      count_in  = count_ff;
      weight_in = weight_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;

      if (cmd.eval) begin
         rem_in  = '0;
         quo_in  = '0;
         dcnt_in = '0;
         if (restart_ff) begin
            radius_in = rpg_pkg::CurRadiusW'(start_ff);
            col_in    = '0;
            row_in    = '0;
            pass_in   = 1'b0;
            count_in  = '0;
            weight_in = '0;
         end else if (series_end) begin
            // series finished: nothing advances
         end else if (zero_dim || (pass_ff && pass_end)) begin
            radius_in = radius_ff + rpg_pkg::CurRadiusW'(step_ff);
            col_in    = '0;
            row_in    = '0;
            pass_in   = 1'b0;
            count_in  = '0;
            weight_in = '0;
         end else begin
            col_in = row_end ? '0 : col_m + rpg_pkg::DimW'(1);
            row_in = row_end ? (pass_end ? '0 : row_m + rpg_pkg::DimW'(1)) : row_m;
            if (!pass_ff) begin
               count_in = count_ff + rpg_pkg::CountW'(on);
               if (pass_end) pass_in = 1'b1;
            end
         end
      end

      if (cmd.div_step) begin
         rem_in  = q_bit ? trial - count_ext : trial;
         quo_in  = quo_next;
         dcnt_in = dcnt_ff + rpg_pkg::DivCntW'(1);
         if (status.div_last) weight_in = (count_ff == '0) ? '0 : quo_next;
      end

      if (csr_wr_en && (csr_index == rpg_pkg::CsrStartRadius)) begin
         radius_in = rpg_pkg::CurRadiusW'(csr_wdata[rpg_pkg::RadiusW-1:0]);
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      if (cmd.eval && status.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = pass_end;
         rsp_data_in  = rpg_pkg::RspDataW'({count_ff,
                                            radius_ff[rpg_pkg::RadiusW-1:0],
                                            (on ? weight_ff : rpg_pkg::WeightW'(0)),
                                            pix_index});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= rpg_pkg::StartRadiusRst;
         step_ff   <= rpg_pkg::RadiusStepRst;
         end_ff    <= rpg_pkg::EndRadiusRst;
         rwidth_ff <= rpg_pkg::RingWidthRst;
         wl_ff     <= rpg_pkg::WidthLog2Rst;
         hl_ff     <= rpg_pkg::HeightLog2Rst;
      end else if (csr_wr_en) begin
         case (csr_index)
            rpg_pkg::CsrStartRadius: start_ff  <= csr_wdata[rpg_pkg::RadiusW-1:0];
            rpg_pkg::CsrRadiusStep:  step_ff   <= csr_wdata[rpg_pkg::RadiusW-1:0];
            rpg_pkg::CsrEndRadius:   end_ff    <= csr_wdata[rpg_pkg::RadiusW-1:0];
            rpg_pkg::CsrRingWidth:   rwidth_ff <= csr_wdata;
            rpg_pkg::CsrWidthLog2:   wl_ff     <= csr_wdata[rpg_pkg::LogW-1:0];
            rpg_pkg::CsrHeightLog2:  hl_ff     <= csr_wdata[rpg_pkg::LogW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= rpg_pkg::CurRadiusW'(rpg_pkg::StartRadiusRst);
         col_ff       <= '0;
         row_ff       <= '0;
         pass_ff      <= 1'b0;
         count_ff     <= '0;
         weight_ff    <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radius_ff    <= radius_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pass_ff      <= pass_in;
         count_ff     <= count_in;
         weight_ff    <= weight_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/ring_pattern_generator.sv
// Ring pattern generator top level. A request runs through accept, square and evaluate,
// and the next one is accepted only back in idle; the request that ends a counting pass
// adds the bit-serial reciprocal of the pixel count. A result is valid the cycle after
// evaluation and waits in the output register while the next request runs.
// Synchronous active-high reset loads the register defaults and clears the scan.
// Depends on rpg_pkg, rpg_ctrl, rpg_datapath.
module ring_pattern_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rpg_pkg::ReqDataW-1:0]  req_tdata,   // [0] restart, rest zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [19:0] pixel_index, [51:20] weight, [63:52] ring_radius, [84:64] ones_count
   output logic [rpg_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                          rsp_tlast,   // last_of_image
   input  logic                          csr_wr_en,
   input  logic [rpg_pkg::CsrIndexW-1:0] csr_index,
   input  logic [rpg_pkg::CsrDataW-1:0]  csr_wdata
);

   rpg_pkg::rpg_cmd_type    cmd;
   rpg_pkg::rpg_status_type status;

   rpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rpg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: tb/sv/tb_ring_pattern_generator.sv
// Testbench for ring_pattern_generator: directed and random pixel requests, with a
// per-request ring scan predictor and an in-order check of every emitted pixel.
// Depends on rpg_pkg and ring_pattern_generator.
`timescale 1ns / 100ps

module tb_ring_pattern_generator;
   import rpg_pkg::*;

   localparam int IdlePercent   = 14;
   localparam int HoldoffCycles = 300;
   localparam int SettleCycles  = 64;
   localparam int DrainLimit    = 4000;
   localparam int CycleLimit    = 600000;
   localparam int RadiusMax     = (1 << RadiusW) - 1;
   localparam int RingWidthMax  = (1 << RingWidthW) - 1;
   localparam int LogMax        = (1 << LogW) - 1;
   localparam int WeightLsb     = IndexW;
   localparam int RadiusLsb     = WeightLsb + WeightW;
   localparam int CountLsb      = RadiusLsb + RadiusW;
   localparam logic [CsrIndexW-1:0] CsrSpareIndex = 3'd7;

   typedef struct packed {
      logic [IndexW-1:0]  pixel_index;
      logic [WeightW-1:0] weight;
      logic [RadiusW-1:0] radius;
      logic [CountW-1:0]  count;
      logic               last;
   } ring_pixel_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata  = '0;   // [0] restart
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [19:0] pixel_index, [51:20] weight, [63:52] ring_radius, [84:64] ones_count
   logic [RspDataW-1:0]   rsp_tdata;
   logic                  rsp_tlast;         // last_of_image
   logic                  csr_wr_en  = 1'b0;
   logic [CsrIndexW-1:0]  csr_index  = '0;
   logic [CsrDataW-1:0]   csr_wdata  = '0;

   // predictor copy of the registers and scan state
   logic [RadiusW-1:0]    cfg_start  = StartRadiusRst;
   logic [RadiusW-1:0]    cfg_step   = RadiusStepRst;
   logic [RadiusW-1:0]    cfg_end    = EndRadiusRst;
   logic [RingWidthW-1:0] cfg_ring_w = RingWidthRst;
   logic [LogW-1:0]       cfg_wlog   = WidthLog2Rst;
   logic [LogW-1:0]       cfg_hlog   = HeightLog2Rst;
   logic [CurRadiusW-1:0] cur_radius = CurRadiusW'(StartRadiusRst);
   logic [DimW-1:0]       col_pos    = '0;
   logic [DimW-1:0]       row_pos    = '0;
   logic                  emitting   = 1'b0;
   logic [CountW-1:0]     ring_count = '0;
   logic [WeightW-1:0]    ring_weight = '0;

   ring_pixel_t pending_pixels[$];
   int  fail_count     = 0;
   int  pixels_checked = 0;
   int  cycle_count    = 0;
   int  holdoff_target = 0;
   int  held_cycles    = 0;
   bit  idle_enable    = 1'b1;

   ring_pattern_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR at %0t: %s", $time, msg);
   endfunction

   function automatic bit pixel_on_ring(input longint x, input longint y);
      longint d4, two_r, thick, outer;
      d4    = 4 * (x * x + y * y);
      two_r = 2 * cur_radius;
      thick = cfg_ring_w;
      outer = (two_r + thick) * (two_r + thick);
      if (d4 >= outer) return 1'b0;
      // thick ring around a small radius covers the center disk
      if (two_r < thick) return 1'b1;
      return d4 > (two_r - thick) * (two_r - thick);
   endfunction

   function automatic void begin_next_image();
      cur_radius  = cur_radius + cfg_step;
      col_pos     = '0;
      row_pos     = '0;
      emitting    = 1'b0;
      ring_count  = '0;
      ring_weight = '0;
   endfunction

   function automatic void apply_register(input logic [CsrIndexW-1:0] index,
                                          input logic [CsrDataW-1:0] value);
      case (index)
         CsrStartRadius: begin
            cfg_start  = value[RadiusW-1:0];
            cur_radius = cfg_start;
         end
         CsrRadiusStep: cfg_step   = value[RadiusW-1:0];
         CsrEndRadius:  cfg_end    = value[RadiusW-1:0];
         CsrRingWidth:  cfg_ring_w = value[RingWidthW-1:0];
         CsrWidthLog2:  cfg_wlog   = value[LogW-1:0];
         CsrHeightLog2: cfg_hlog   = value[LogW-1:0];
         default: ;
      endcase
   endfunction

   // one request: returns 1 and the pixel when the request yields a result
   function automatic bit step_ring_scan(input logic restart, output ring_pixel_t px);
      int wl, hl, w, h, col, row;
      bit on, row_end, pass_end;
      px = '0;
      if (restart) begin
         cur_radius  = cfg_start;
         col_pos     = '0;
         row_pos     = '0;
         emitting    = 1'b0;
         ring_count  = '0;
         ring_weight = '0;
         return 1'b0;
      end
      // series over: nothing moves until end_radius is raised or a restart
      if (!emitting && col_pos == 0 && row_pos == 0 && cur_radius > cfg_end) return 1'b0;
      wl = (cfg_wlog > MaxDimLog2) ? MaxDimLog2 : cfg_wlog;
      hl = (cfg_hlog > MaxDimLog2) ? MaxDimLog2 : cfg_hlog;
      if (wl == 0 || hl == 0) begin
         begin_next_image();
         return 1'b0;
      end
      w   = 1 << wl;
      h   = 1 << hl;
      col = col_pos & (w - 1);
      row = row_pos & (h - 1);
      on  = pixel_on_ring(col - w / 2, row - h / 2);
      row_end  = (col + 1) >= w;
      pass_end = row_end && (row + 1) >= h;
      col_pos  = row_end ? 0 : col + 1;
      row_pos  = row_end ? (pass_end ? 0 : row + 1) : row;
      if (!emitting) begin
         if (on) ring_count++;
         if (pass_end) begin
            ring_weight = (ring_count != 0) ? 32'h8000_0000 / ring_count : '0;
            emitting = 1'b1;
         end
         return 1'b0;
      end
      px.pixel_index = ((col + w / 2) & (w - 1)) + ((row + h / 2) & (h - 1)) * w;
      px.weight      = on ? ring_weight : '0;
      px.radius      = cur_radius[RadiusW-1:0];
      px.count       = ring_count;
      px.last        = pass_end;
      if (pass_end) begin_next_image();
      return 1'b1;
   endfunction

   // result check first, then prediction for the request taken at the same edge
   always @(posedge clock) begin : pixel_check
      ring_pixel_t got, want, produced;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.pixel_index = rsp_tdata[IndexW-1:0];
            got.weight      = rsp_tdata[WeightLsb +: WeightW];
            got.radius      = rsp_tdata[RadiusLsb +: RadiusW];
            got.count       = rsp_tdata[CountLsb +: CountW];
            got.last        = rsp_tlast;
            if (pending_pixels.size() == 0) begin
               note_failure($sformatf("unexpected pixel idx %0d w %h r %0d n %0d last %0b",
                  got.pixel_index, got.weight, got.radius, got.count, got.last));
            end else begin
               want = pending_pixels.pop_front();
               pixels_checked++;
               if (got.pixel_index !== want.pixel_index || got.weight !== want.weight ||
                   got.radius !== want.radius || got.count !== want.count ||
                   got.last !== want.last) begin
                  note_failure($sformatf(
                     "pixel exp idx %0d w %h r %0d n %0d last %0b, got idx %0d w %h r %0d n %0d last %0b",
                     want.pixel_index, want.weight, want.radius, want.count, want.last,
                     got.pixel_index, got.weight, got.radius, got.count, got.last));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (step_ring_scan(req_tdata[0], produced)) pending_pixels.push_back(produced);
         end
      end
   end

   // receiver: random stalls, plus a counted hold-off when requested
   always @(posedge clock) begin
      if (held_cycles < holdoff_target) begin
         held_cycles <= held_cycles + 1;
         rsp_tready  <= 1'b0;
      end else if (!idle_enable) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IdlePercent);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("ring_pattern_generator test failed");
         $finish;
      end
   end

   task automatic send_request(input logic restart);
      if (idle_enable && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataW'(restart);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_advances(input int n);
      repeat (n) send_request(1'b0);
   endtask

   // stop requests, wait for every pending pixel, then let the block go idle
   task automatic wait_for_results();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (pending_pixels.size() != 0) begin
         note_failure($sformatf("%0d pixels never emitted", pending_pixels.size()));
         pending_pixels.delete();
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexW-1:0] index, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CsrDataW-1:0];
      apply_register(index, value[CsrDataW-1:0]);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      // defaults give a 1024x1024 image, so only a few counting steps there
      send_advances(3);
      wait_for_results();
      // shrink mid-pass: scan wraps into a 2x2 image, radius 7 then ends the series
      write_register(CsrWidthLog2, 1);
      write_register(CsrHeightLog2, 1);
      send_advances(9);
      wait_for_results();
   endtask

   task automatic test_single_pixel_ring();
      // r=2, t=2 on 2x2: only the corner pixel is on the ring, weight is full scale
      write_register(CsrStartRadius, 2);
      write_register(CsrRadiusStep, 1);
      write_register(CsrEndRadius, 2);
      write_register(CsrRingWidth, 2);
      send_request(1'b1);
      send_advances(9);
      wait_for_results();
   endtask

   task automatic test_empty_and_flat_images();
      // thin ring far outside the image: zero count, zero weight
      write_register(CsrStartRadius, RadiusMax);
      write_register(CsrRadiusStep, RadiusMax);
      write_register(CsrEndRadius, RadiusMax);
      write_register(CsrRingWidth, 1);
      send_request(1'b1);
      send_advances(9);
      wait_for_results();
      // zero width: each request skips a whole image with no pixel until the series ends
      write_register(CsrStartRadius, 1);
      write_register(CsrRadiusStep, 1);
      write_register(CsrEndRadius, 3);
      write_register(CsrWidthLog2, 0);
      write_register(CsrHeightLog2, 2);
      write_register(CsrSpareIndex, RingWidthMax);
      send_request(1'b1);
      send_advances(5);
      wait_for_results();
      // raising end_radius resumes the finished series
      write_register(CsrEndRadius, 5);
      write_register(CsrWidthLog2, 1);
      write_register(CsrHeightLog2, 1);
      write_register(CsrRingWidth, RingWidthW'(RingWidthRst));
      send_advances(17);
      wait_for_results();
   endtask

   task automatic test_full_width_images();
      idle_enable <= 1'b0;
      // oversized log2 saturates to 1024 columns
      write_register(CsrWidthLog2, LogMax);
      write_register(CsrHeightLog2, 1);
      write_register(CsrStartRadius, 300);
      write_register(CsrRadiusStep, 1);
      write_register(CsrEndRadius, 301);
      write_register(CsrRingWidth, RingWidthMax);
      send_request(1'b1);
      send_advances(4096);
      wait_for_results();
      write_register(CsrWidthLog2, 1);
      write_register(CsrHeightLog2, 12);
      write_register(CsrRingWidth, 40);
      send_advances(4097);
      wait_for_results();
      idle_enable <= 1'b1;
   endtask

   task automatic test_output_backpressure();
      write_register(CsrStartRadius, 3);
      write_register(CsrRadiusStep, 1);
      write_register(CsrEndRadius, 20);
      write_register(CsrRingWidth, 4);
      write_register(CsrWidthLog2, 2);
      write_register(CsrHeightLog2, 1);
      send_request(1'b1);
      // receiver holds off while requests keep coming, so the input must stall
      holdoff_target <= holdoff_target + HoldoffCycles;
      send_advances(40);
      wait_for_results();
      send_advances(24);
      wait_for_results();
   endtask

   task automatic test_random_series();
      int phase, goal;
      phase = 0;
      goal  = pixels_checked + 60;
      while (phase < 8 || (pixels_checked < goal && phase < 24)) begin
         idle_enable <= !(phase == 2 || phase == 3);
         if ($urandom_range(99) < 30)
            write_register(CsrStartRadius,
               ($urandom_range(99) < 10) ? RadiusMax : $urandom_range(1, 10));
         if ($urandom_range(99) < 70)
            write_register(CsrRadiusStep,
               ($urandom_range(99) < 10) ? RadiusMax : $urandom_range(1, 3));
         if ($urandom_range(99) < 70)
            write_register(CsrEndRadius,
               ($urandom_range(99) < 15) ? RadiusMax : $urandom_range(1, 16));
         if ($urandom_range(99) < 70)
            write_register(CsrRingWidth,
               ($urandom_range(99) < 10) ? RingWidthMax : $urandom_range(1, 12));
         if ($urandom_range(99) < 70)
            write_register(CsrWidthLog2,
               ($urandom_range(99) < 8) ? $urandom_range(11, LogMax) : $urandom_range(0, 3));
         if ($urandom_range(99) < 70)
            write_register(CsrHeightLog2,
               ($urandom_range(99) < 8) ? $urandom_range(11, LogMax) : $urandom_range(0, 3));
         // mostly plain advances; a stray restart breaks the image now and then
         repeat (50) send_request($urandom_range(99) < 3);
         wait_for_results();
         phase++;
      end
      idle_enable <= 1'b1;
   endtask

   initial begin : main_sequence
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_single_pixel_ring();
      test_empty_and_flat_images();
      test_full_width_images();
      test_output_backpressure();
      test_random_series();
      wait_for_results();
      if (fail_count == 0) begin
         $display("ring_pattern_generator test passed");
      end else begin
         $display("ring_pattern_generator test failed");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/rpg_pkg.sv
hdl/rpg_ctrl.sv
hdl/rpg_datapath.sv
hdl/ring_pattern_generator.sv
tb/sv/tb_ring_pattern_generator.sv
